// ===== sv/ppq_pkg.sv =====
package ppq_pkg;

  // Index width limit and palette geometry
  localparam int MAX_BITS    = 8;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int COMP_W      = 8;
  localparam int ENTRY_W     = 3 * COMP_W;
  localparam int VALUE_W     = 8;
  localparam int DIST_W      = 10;
  localparam int BITS_W      = 4;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = BITS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_VALUE = 1'b1;

  // Field codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_QUANTIZE = 1'b1;
  localparam logic MODE_GRAY   = 1'b0;
  localparam logic MODE_COLOR  = 1'b1;

  // Luma arithmetic, Q16 weights; full scale is 255 * 65536
  localparam int LUMA_W      = 24;
  localparam int PROD_W      = LUMA_W + VALUE_W;
  localparam int QT_W        = 16;
  localparam int RECIP_W     = 25;
  localparam logic [LUMA_W-1:0] LUMA_WR = 24'd19595;
  localparam logic [LUMA_W-1:0] LUMA_WG = 24'd38470;
  localparam logic [LUMA_W-1:0] LUMA_WB = 24'd7471;
  // t / 255 is approximated as (t * 257) >> 16, then corrected once
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'd257;
  localparam logic [QT_W-1:0]    DIV_255   = 16'd255;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_GRAY,
    KIND_COLOR
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [PAL_AW-1:0]       entry_index;
    logic [COMP_W-1:0]       red;
    logic [COMP_W-1:0]       green;
    logic [COMP_W-1:0]       blue;
  } queue_item_t;

  typedef struct packed {
    logic                    palette_mode;
    logic [VALUE_W-1:0]      max_index;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GRAY_LUMA,
    BK_GRAY_SCALE,
    BK_GRAY_RECIP,
    BK_GRAY_FIX,
    BK_SCAN,
    BK_EMIT
  } back_state_t;

  // Clamp the programmed index width to 1..MAX_BITS
  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] b;
    b = bits;
    if (b < BITS_W'(1)) b = BITS_W'(1);
    if (b > BITS_W'(MAX_BITS)) b = BITS_W'(MAX_BITS);
    return b;
  endfunction

  // Largest index for a given width: 2^bits - 1
  function automatic logic [VALUE_W-1:0] max_index_of(input logic [BITS_W-1:0] bits);
    logic [VALUE_W:0] m;
    m = ((VALUE_W + 1)'(1) << clamp_bits(bits)) - (VALUE_W + 1)'(1);
    return m[VALUE_W-1:0];
  endfunction

endpackage

// ===== sv/ppq_if.sv =====
interface ppq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [ppq_pkg::PAL_AW-1:0]  entry_index;
  logic [ppq_pkg::COMP_W-1:0]  red;
  logic [ppq_pkg::COMP_W-1:0]  green;
  logic [ppq_pkg::COMP_W-1:0]  blue;

  modport source (output valid, operation, entry_index, red, green, blue, input ready);
  modport sink   (input valid, operation, entry_index, red, green, blue, output ready);
endinterface

interface ppq_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppq_pkg::VALUE_W-1:0] palette_value;
  logic [ppq_pkg::DIST_W-1:0]  match_distance;

  modport source (output valid, palette_value, match_distance, input ready);
  modport sink   (input valid, palette_value, match_distance, output ready);
endinterface

// ===== sv/ppq_ram.sv =====
module ppq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ppq_front.sv =====
module ppq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ppq_in_if.sink                          in_chan,
  input  logic                            q_full,
  output logic                            q_push,
  output ppq_pkg::queue_item_t            q_item,
  output ppq_pkg::cfg_t                   cfg
);
  import ppq_pkg::*;

  logic              palette_mode_r;
  logic [BITS_W-1:0] bits_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_mode_r <= MODE_GRAY;
      bits_r         <= BITS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PALETTE_MODE:   palette_mode_r <= cfg_wdata[0];
        CFG_BITS_PER_VALUE: bits_r         <= cfg_wdata[BITS_W-1:0];
        default:            ;
      endcase
    end
  end

  assign cfg.palette_mode = palette_mode_r;
  assign cfg.max_index    = max_index_of(bits_r);

  // Accept while the queue has room
  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Classify the item for the back end
  always_comb begin
    q_item.entry_index = in_chan.entry_index;
    q_item.red         = in_chan.red;
    q_item.green       = in_chan.green;
    q_item.blue        = in_chan.blue;
    if (in_chan.operation == OP_LOAD) begin
      q_item.kind = KIND_LOAD;
    end else if (palette_mode_r == MODE_COLOR) begin
      q_item.kind = KIND_COLOR;
    end else begin
      q_item.kind = KIND_GRAY;
    end
  end

endmodule

// ===== sv/ppq_queue.sv =====
module ppq_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ppq_pkg::queue_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output ppq_pkg::queue_item_t  pop_item
);
  import ppq_pkg::*;

  queue_item_t         slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic [QUEUE_CW-1:0] count_nxt;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/ppq_back.sv =====
module ppq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppq_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  ppq_pkg::queue_item_t  q_item,
  output logic                  q_pop,
  ppq_out_if.source             out_chan
);
  import ppq_pkg::*;

  back_state_t state_r, state_nxt;

  logic [COMP_W-1:0]  pix_red_r, pix_red_nxt;
  logic [COMP_W-1:0]  pix_green_r, pix_green_nxt;
  logic [COMP_W-1:0]  pix_blue_r, pix_blue_nxt;
  logic [LUMA_W-1:0]  luma_r, luma_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [QT_W-1:0]    qt_r, qt_nxt;
  logic [VALUE_W-1:0] q0_r, q0_nxt;
  logic [PAL_AW-1:0]  scan_addr_r, scan_addr_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               cmp_valid_r, cmp_valid_nxt;
  logic [PAL_AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [VALUE_W-1:0] best_r, best_nxt;
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;

  logic               out_free;
  logic               emit_fire;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [COMP_W-1:0]  ent_red, ent_green, ent_blue;
  logic [COMP_W-1:0]  diff_red, diff_green, diff_blue;
  logic [DIST_W-1:0]  entry_dist;
  logic [RECIP_W-1:0] recip;
  logic [QT_W-1:0]    rem;
  logic [VALUE_W:0]   q_fix;

  // Palette store, written by load items, read by the scan
  ppq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.entry_index),
    .wdata ({q_item.red, q_item.green, q_item.blue}),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            KIND_GRAY:  state_nxt = BK_GRAY_LUMA;
            KIND_COLOR: state_nxt = BK_SCAN;
            default:    state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_GRAY_LUMA:  state_nxt = BK_GRAY_SCALE;
      BK_GRAY_SCALE: state_nxt = BK_GRAY_RECIP;
      BK_GRAY_RECIP: state_nxt = BK_GRAY_FIX;
      BK_GRAY_FIX:   state_nxt = BK_EMIT;
      BK_SCAN: begin
        if (cmp_valid_r && cmp_idx_r == cfg.max_index) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = (state_r == BK_IDLE) && q_valid;
    ram_we    = q_pop && (q_item.kind == KIND_LOAD);
    emit_fire = (state_r == BK_EMIT) && out_free;
  end

  // Distance of the entry read last cycle
  assign ent_red    = ram_rdata[ENTRY_W-1 -: COMP_W];
  assign ent_green  = ram_rdata[2*COMP_W-1 -: COMP_W];
  assign ent_blue   = ram_rdata[COMP_W-1:0];
  assign diff_red   = (ent_red > pix_red_r) ? ent_red - pix_red_r : pix_red_r - ent_red;
  assign diff_green = (ent_green > pix_green_r) ? ent_green - pix_green_r
                                                : pix_green_r - ent_green;
  assign diff_blue  = (ent_blue > pix_blue_r) ? ent_blue - pix_blue_r : pix_blue_r - ent_blue;
  assign entry_dist = DIST_W'(diff_red) + DIST_W'(diff_green) + DIST_W'(diff_blue);

  // Luma scaling: divide by 65536 by shift, then by 255 via reciprocal
  assign recip = RECIP_W'(prod_r[PROD_W-1 -: QT_W]) * RECIP_255;
  assign rem   = qt_r - QT_W'(q0_r) * DIV_255;

  // Datapath
  always_comb begin
    pix_red_nxt    = pix_red_r;
    pix_green_nxt  = pix_green_r;
    pix_blue_nxt   = pix_blue_r;
    luma_nxt       = luma_r;
    prod_nxt       = prod_r;
    qt_nxt         = qt_r;
    q0_nxt         = q0_r;
    scan_addr_nxt  = scan_addr_r;
    issue_done_nxt = issue_done_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_nxt       = best_r;
    best_dist_nxt  = best_dist_r;
    q_fix          = '0;

    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          pix_red_nxt    = q_item.red;
          pix_green_nxt  = q_item.green;
          pix_blue_nxt   = q_item.blue;
          scan_addr_nxt  = '0;
          issue_done_nxt = 1'b0;
          cmp_valid_nxt  = 1'b0;
        end
      end
      BK_GRAY_LUMA: begin
        luma_nxt = LUMA_WR * LUMA_W'(pix_red_r) + LUMA_WG * LUMA_W'(pix_green_r)
                 + LUMA_WB * LUMA_W'(pix_blue_r);
      end
      BK_GRAY_SCALE: begin
        prod_nxt = PROD_W'(luma_r) * PROD_W'(cfg.max_index);
      end
      BK_GRAY_RECIP: begin
        qt_nxt = prod_r[PROD_W-1 -: QT_W];
        q0_nxt = recip[QT_W +: VALUE_W];
      end
      BK_GRAY_FIX: begin
        q_fix = (VALUE_W + 1)'(q0_r) + (VALUE_W + 1)'(rem >= DIV_255);
        if (q_fix > (VALUE_W + 1)'(cfg.max_index)) begin
          best_nxt = cfg.max_index;
        end else begin
          best_nxt = q_fix[VALUE_W-1:0];
        end
        best_dist_nxt = '0;
      end
      BK_SCAN: begin
        // Issue one read per cycle, compare in the cycle after
        cmp_valid_nxt = !issue_done_r;
        cmp_idx_nxt   = scan_addr_r;
        if (!issue_done_r) begin
          if (scan_addr_r == cfg.max_index) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + PAL_AW'(1);
          end
        end
        // First minimum wins
        if (cmp_valid_r && (cmp_idx_r == '0 || entry_dist < best_dist_r)) begin
          best_nxt      = cmp_idx_r;
          best_dist_nxt = entry_dist;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_dist_nxt  = out_dist_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = best_r;
      out_dist_nxt  = best_dist_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.palette_value  = out_value_r;
  assign out_chan.match_distance = out_dist_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      issue_done_r <= 1'b0;
      cmp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pix_red_r   <= pix_red_nxt;
    pix_green_r <= pix_green_nxt;
    pix_blue_r  <= pix_blue_nxt;
    luma_r      <= luma_nxt;
    prod_r      <= prod_nxt;
    qt_r        <= qt_nxt;
    q0_r        <= q0_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    out_value_r <= out_value_nxt;
    out_dist_r  <= out_dist_nxt;
  end

endmodule

// ===== sv/pixel_palette_quantizer.sv =====
// Channel   Dir  Handshake          Payload
// in_chan   in   valid/ready        operation, entry_index, red, green, blue
// out_chan  out  valid/ready        palette_value, match_distance
// cfg_*     in   cfg_we (no wait)   cfg_index, cfg_wdata
//
// Load items are written to the palette as they are popped (one palette write port).
// Grayscale quantize steps through luma, scale, reciprocal, correction and emit.
// Color quantize scans entries 0..2^bits-1, one palette read per entry via the RAM port.
// A 4-entry queue lets the input keep transferring while the back end is busy, until it fills.
// Reset is synchronous; the palette store is not cleared.
module pixel_palette_quantizer (
  input  logic                            clk,
  input  logic                            rst_n,
  ppq_in_if.sink                          in_chan,
  ppq_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ppq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ppq_pkg::*;

  cfg_t        cfg;
  logic        q_full;
  logic        q_push;
  queue_item_t push_item;
  logic        q_pop;
  logic        q_valid;
  queue_item_t pop_item;

  ppq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item),
    .cfg       (cfg)
  );

  ppq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  ppq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== sv/ppq_checker.sv =====
module ppq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_we,
  input logic [ppq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ppq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ppq_pkg::VALUE_W-1:0]     out_value,
  input logic [ppq_pkg::DIST_W-1:0]      out_dist
);
  import ppq_pkg::*;

  logic [BITS_W-1:0] bits_r;

  // Shadow of the index width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= BITS_W'(1);
    end else if (cfg_we && cfg_index == CFG_BITS_PER_VALUE) begin
      bits_r <= cfg_wdata[BITS_W-1:0];
    end
  end

  // No result comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Index stays within the configured range
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value <= max_index_of(bits_r))
    else $error("palette index above max index");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_dist))
    else $error("stalled result changed");

  // L1 distance of three 8-bit components cannot exceed 765
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dist <= DIST_W'(765))
    else $error("match distance out of range");

endmodule

bind pixel_palette_quantizer ppq_checker u_ppq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.palette_value),
  .out_dist  (out_chan.match_distance)
);

// ===== verif/tb_pixel_palette_quantizer.sv =====
module tb_pixel_palette_quantizer;
  import ppq_pkg::*;

  // Q16 luma weights and full scale of the luma sum
  localparam longint unsigned GRAY_WR   = 19595;
  localparam longint unsigned GRAY_WG   = 38470;
  localparam longint unsigned GRAY_WB   = 7471;
  localparam longint unsigned GRAY_FULL = 255 * 65536;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DIST_W-1:0]  distance;
  } quant_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ppq_in_if  in_ch ();
  ppq_out_if out_ch ();

  pixel_palette_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: palette, registers, results still to come
  logic [ENTRY_W-1:0] palette_copy [PAL_DEPTH];
  logic               mode_reg;
  logic [BITS_W-1:0]  width_reg;
  quant_result_t      expected_results [$];

  int mismatch_count;
  bit no_idle;
  bit out_took;
  int out_wait;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Programmed width, clamped to 1..MAX_BITS
  function automatic int width_used();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_BITS) w = MAX_BITS;
    return w;
  endfunction

  function automatic int max_index();
    return (1 << width_used()) - 1;
  endfunction

  function automatic int comp_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected index and distance of one pixel under the current settings
  function automatic quant_result_t quantize_pixel(input logic [7:0] r, g, b);
    quant_result_t    res;
    longint unsigned  luma;
    longint unsigned  q;
    longint unsigned  top;
    int               best;
    int               best_d;
    int               d;
    logic [ENTRY_W-1:0] e;
    res = '0;
    top = longint'(max_index());
    if (mode_reg == MODE_GRAY) begin
      luma = GRAY_WR * r + GRAY_WG * g + GRAY_WB * b;
      q = (luma * top) / GRAY_FULL;
      if (q > top) q = top;
      res.value = VALUE_W'(q);
      res.distance = '0;
    end else begin
      best = 0;
      best_d = 0;
      for (int i = 0; i <= max_index(); i++) begin
        e = palette_copy[i];
        d = comp_gap(e[23:16], r) + comp_gap(e[15:8], g) + comp_gap(e[7:0], b);
        // first minimum wins on a tie
        if (i == 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      res.value = VALUE_W'(best);
      res.distance = DIST_W'(best_d);
    end
    return res;
  endfunction

  // Present one item, wait for its transfer, then update the shadow
  task automatic send_item(input logic op, input logic [7:0] idx, input logic [7:0] r, g, b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.red         <= r;
    in_ch.green       <= g;
    in_ch.blue        <= b;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (op == OP_LOAD) begin
      palette_copy[idx] = {r, g, b};
    end else begin
      expected_results.push_back(quantize_pixel(r, g, b));
    end
  endtask

  // Stop sending and let the block run dry; trailing loads give no result
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PALETTE_MODE) mode_reg = data[0];
    else width_reg = data;
    @(posedge clk);
  endtask

  // Only bit 0 counts for the mode; upper bits get random junk
  task automatic set_mode(input logic m);
    write_reg(CFG_PALETTE_MODE, {3'($urandom), m});
  endtask

  task automatic set_width(input int w);
    write_reg(CFG_BITS_PER_VALUE, BITS_W'(w));
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] gray_comp();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Luma extremes, pure primaries and out-of-range widths, reset defaults first
  task automatic test_gray_extremes();
    no_idle = 1'b0;
    send_item(OP_QUANTIZE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(OP_QUANTIZE, 8'd255, 8'd255, 8'd255, 8'd255);
    set_width(8);
    send_item(OP_QUANTIZE, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd255, 8'd0, 8'd0, 8'd0);
    send_item(OP_QUANTIZE, 8'd1, 8'd255, 8'd0, 8'd0);
    send_item(OP_QUANTIZE, 8'd2, 8'd0, 8'd255, 8'd0);
    send_item(OP_QUANTIZE, 8'd3, 8'd0, 8'd0, 8'd255);
    // width 0 acts as 1
    set_width(0);
    send_item(OP_QUANTIZE, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd0, 8'd128, 8'd128, 8'd128);
    // width beyond MAX_BITS acts as MAX_BITS
    set_width(15);
    send_item(OP_QUANTIZE, 8'd0, 8'd255, 8'd255, 8'd255);
  endtask

  // Small palettes: exact hits, ties, maximum distance, load past active size
  task automatic test_color_directed();
    set_width(1);
    send_item(OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(OP_LOAD, 8'd1, 8'd255, 8'd255, 8'd255);
    send_item(OP_LOAD, 8'd2, 8'd100, 8'd100, 8'd100);
    send_item(OP_LOAD, 8'd3, 8'd100, 8'd100, 8'd100);
    send_item(OP_LOAD, 8'd255, 8'd10, 8'd20, 8'd30);
    set_mode(MODE_COLOR);
    send_item(OP_QUANTIZE, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd0, 8'd255, 8'd0, 8'd0);
    set_width(2);
    send_item(OP_QUANTIZE, 8'd0, 8'd100, 8'd100, 8'd100);
    send_item(OP_QUANTIZE, 8'd0, 8'd90, 8'd100, 8'd110);
    // two white entries: black pixel is 765 away from both, index 0 wins
    set_width(1);
    send_item(OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // Write every entry so any width can be searched later; some duplicates for ties
  task automatic test_palette_fill();
    logic [ENTRY_W-1:0] c;
    no_idle = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < PAL_DEPTH; i++) begin
      c = ENTRY_W'($urandom);
      if (i > 0 && $urandom_range(0, 7) == 0) c = palette_copy[i-1];
      send_item(OP_LOAD, 8'(i), c[23:16], c[15:8], c[7:0]);
    end
  endtask

  task automatic test_random_gray();
    int widths [6];
    logic [ENTRY_W-1:0] c;
    widths = '{1, 8, 0, 15, $urandom_range(2, 7), $urandom_range(2, 7)};
    set_mode(MODE_GRAY);
    foreach (widths[k]) begin
      set_width(widths[k]);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (10) begin
        if ($urandom_range(0, 6) == 0) begin
          c = ENTRY_W'($urandom);
          send_item(OP_LOAD, 8'($urandom), c[23:16], c[15:8], c[7:0]);
        end else begin
          send_item(OP_QUANTIZE, 8'($urandom), gray_comp(), gray_comp(), gray_comp());
        end
      end
    end
  endtask

  // Mostly small palettes, a few full-size searches
  task automatic test_random_color();
    int widths [10];
    int count;
    int pick;
    logic [ENTRY_W-1:0] c;
    widths = '{1, 2, 3, 4, $urandom_range(2, 6), 5, 8, 9, 0, 6};
    set_mode(MODE_COLOR);
    foreach (widths[k]) begin
      set_width(widths[k]);
      no_idle = ($urandom_range(0, 3) == 0);
      count = (widths[k] >= 7) ? 8 : 10;
      repeat (count) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // reload an entry, sometimes as a copy of another
          c = ($urandom_range(0, 2) == 0) ? palette_copy[$urandom_range(0, 255)]
                                          : ENTRY_W'($urandom);
          send_item(OP_LOAD, 8'($urandom), c[23:16], c[15:8], c[7:0]);
        end else if (pick < 7) begin
          c = palette_copy[$urandom_range(0, max_index())];
          send_item(OP_QUANTIZE, 8'($urandom), nudge(c[23:16]), nudge(c[15:8]),
                    nudge(c[7:0]));
        end else if (pick == 7) begin
          send_item(OP_QUANTIZE, 8'($urandom), {8{1'($urandom)}}, {8{1'($urandom)}},
                    {8{1'($urandom)}});
        end else begin
          c = ENTRY_W'($urandom);
          send_item(OP_QUANTIZE, 8'($urandom), c[23:16], c[15:8], c[7:0]);
        end
      end
    end
  endtask

  // Result check; the transfer completes at the next rising edge
  always @(negedge clk) begin
    quant_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_took = 1'b1;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: value %0d distance %0d", $time,
                 out_ch.palette_value, out_ch.match_distance);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.palette_value !== want.value) begin
          mismatch_count++;
          $display("%0t: palette_value expected %0d actual %0d", $time, want.value,
                   out_ch.palette_value);
        end
        if (out_ch.match_distance !== want.distance) begin
          mismatch_count++;
          $display("%0t: match_distance expected %0d actual %0d", $time, want.distance,
                   out_ch.match_distance);
        end
      end
    end
  end

  // Receiver stall: a fresh random wait after each result transfer, none when no_idle is set
  always @(posedge clk) begin
    if (out_took) begin
      out_took = 1'b0;
      out_wait = no_idle ? 0 : $urandom_range(0, 4);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= (out_wait == 0);
  end

  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    out_ch.ready      = 1'b0;
    mode_reg          = MODE_GRAY;
    width_reg         = BITS_W'(1);
    mismatch_count    = 0;
    no_idle           = 1'b0;
    out_took          = 1'b0;
    out_wait          = 0;
    foreach (palette_copy[i]) begin
      palette_copy[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_gray_extremes();
    test_color_directed();
    test_palette_fill();
    test_random_gray();
    test_random_color();

    settle();
    repeat (300) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
